// ===== design/normalized_name_fnv1a_hash_macros.svh =====
// ----------------------------------------------------------------------------
// normalized_name_fnv1a_hash_macros
// Assertion macros shared by the hasher's modules. Each expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef NORMALIZED_NAME_FNV1A_HASH_MACROS_SVH
`define NORMALIZED_NAME_FNV1A_HASH_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define NNFH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition holds in the cycle after the trigger
`define NNFH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/nnfh_pkg.sv =====
// ----------------------------------------------------------------------------
// nnfh_pkg
// Types, constants and character helpers for the normalized-name hasher.
// ----------------------------------------------------------------------------
package nnfh_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] MIX_PRIME = 32'd16777619;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_UNDER  = 8'h5F;
  localparam logic [7:0]  CASE_BIT  = 8'h20;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX_SPACE,
    S_MIX_CHAR,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // request accepted, latch item
    logic mix_space;  // hash a space
    logic mix_char;   // hash the latched letter
    logic emit;       // move result to output, clear name state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_letter;  // incoming request carries a letter
    logic in_end;     // incoming request closes the name
    logic pending;    // a separator space waits to be hashed
    logic end_r;      // latched request closes the name
    logic out_busy;   // output register holds a result that is stalled
  } sts_t;

  // Fold upper case to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41:8'h5A]}) r = b | CASE_BIT;
    return r;
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return b inside {[8'h61:8'h7A]};
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return b inside {CH_SPACE, CH_UNDER};
  endfunction

endpackage

// ===== design/normalized_name_fnv1a_hash.sv =====
// ----------------------------------------------------------------------------
// normalized_name_fnv1a_hash
// Normalized-name FNV-1a 32-bit hasher, one name byte per request.
// ----------------------------------------------------------------------------
// Sequencing: a dropped byte, separator or idle request is taken in the idle
//   state alone; a letter adds a multiply step, after a space step if a space
//   is pending (one multiply per cycle); an end request adds an emit step that
//   waits while a stalled result holds the output. in_stall is high outside idle.
// out_valid is registered: it rises in the cycle after the emit step.
// Reset: synchronous, active low; hash to offset basis, flags and valid clear.

module normalized_name_fnv1a_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_has_char,
  input  logic        in_end_of_name,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_name_hash
);

  nnfh_pkg::cmd_t cmd;
  nnfh_pkg::sts_t sts;

  // Sequencer
  nnfh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hash datapath
  nnfh_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char_byte   (in_char_byte),
    .in_has_char    (in_has_char),
    .in_end_of_name (in_end_of_name),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_name_hash  (out_name_hash)
  );

endmodule

// ===== design/nnfh_dpath.sv =====
// ----------------------------------------------------------------------------
// nnfh_dpath
// Hash datapath: item latch, shared FNV multiply step, name flags and the
// output register.
// ----------------------------------------------------------------------------
`include "normalized_name_fnv1a_hash_macros.svh"

module nnfh_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_char_byte,
  input  logic                in_has_char,
  input  logic                in_end_of_name,
  input  nnfh_pkg::cmd_t      cmd,
  output nnfh_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_name_hash
);

  logic [7:0]  lowered;
  logic        letter_in;
  logic        sep_in;
  logic [7:0]  byte_r;
  logic        end_r;
  logic [31:0] hash_r, hash_nxt;
  logic        seen_r, seen_nxt;
  logic        pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r;
  logic [7:0]  mix_op;
  logic [31:0] mix_res;

  // Classify the incoming byte
  assign lowered   = nnfh_pkg::fold_case(in_char_byte);
  assign letter_in = in_has_char && nnfh_pkg::is_lower(lowered);
  assign sep_in    = in_has_char && nnfh_pkg::is_sep(in_char_byte);

  // One FNV-1a step: xor then multiply by the prime, mod 2^32
  assign mix_op  = cmd.mix_space ? nnfh_pkg::CH_SPACE : byte_r;
  assign mix_res = (hash_r ^ {24'd0, mix_op}) * nnfh_pkg::MIX_PRIME;

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= lowered;
      end_r  <= in_end_of_name;
    end
  end

  // Name state next value
  always_comb begin
    hash_nxt = hash_r;
    seen_nxt = seen_r;
    pend_nxt = pend_r;
    if (cmd.load && sep_in) pend_nxt = seen_r;
    if (cmd.mix_space) begin
      hash_nxt = mix_res;
      pend_nxt = 1'b0;
    end
    if (cmd.mix_char) begin
      hash_nxt = mix_res;
      seen_nxt = 1'b1;
    end
    if (cmd.emit) begin
      hash_nxt = nnfh_pkg::FNV_BASIS;
      seen_nxt = 1'b0;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= nnfh_pkg::FNV_BASIS;
      seen_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      hash_r <= hash_nxt;
      seen_r <= seen_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_hash_r <= seen_r ? hash_r : 32'd0;
  end

  assign out_valid     = out_valid_r;
  assign out_name_hash = out_hash_r;

  // Status back to the controller
  always_comb begin
    sts.in_letter = letter_in;
    sts.in_end    = in_end_of_name;
    sts.pending   = pend_r;
    sts.end_r     = end_r;
    sts.out_busy  = out_valid_r && out_stall;
  end

  `NNFH_ASSERT_SAME(a_one_mix, cmd.mix_space, !cmd.mix_char)
  `NNFH_ASSERT_NEXT(a_emit_clears, cmd.emit,
                    hash_r == nnfh_pkg::FNV_BASIS && !seen_r && !pend_r)
  `NNFH_ASSERT_NEXT(a_space_used, cmd.mix_space, !pend_r)

endmodule

// ===== design/nnfh_ctrl.sv =====
// ----------------------------------------------------------------------------
// nnfh_ctrl
// Sequencer: accepts a request, schedules the multiply steps it needs and
// the hand-off of the result.
// ----------------------------------------------------------------------------
`include "normalized_name_fnv1a_hash_macros.svh"

module nnfh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nnfh_pkg::sts_t      sts,
  output nnfh_pkg::cmd_t      cmd
);

  nnfh_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nnfh_pkg::S_IDLE: begin
        if (in_valid) begin
          if (sts.in_letter && sts.pending) state_nxt = nnfh_pkg::S_MIX_SPACE;
          else if (sts.in_letter)           state_nxt = nnfh_pkg::S_MIX_CHAR;
          else if (sts.in_end)              state_nxt = nnfh_pkg::S_EMIT;
        end
      end
      nnfh_pkg::S_MIX_SPACE: state_nxt = nnfh_pkg::S_MIX_CHAR;
      nnfh_pkg::S_MIX_CHAR: begin
        state_nxt = sts.end_r ? nnfh_pkg::S_EMIT : nnfh_pkg::S_IDLE;
      end
      nnfh_pkg::S_EMIT: begin
        if (!sts.out_busy) state_nxt = nnfh_pkg::S_IDLE;
      end
      default: state_nxt = nnfh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= nnfh_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      nnfh_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      nnfh_pkg::S_MIX_SPACE: cmd.mix_space = 1'b1;
      nnfh_pkg::S_MIX_CHAR:  cmd.mix_char  = 1'b1;
      nnfh_pkg::S_EMIT:      cmd.emit      = !sts.out_busy;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  `NNFH_ASSERT_SAME(a_stall_busy, state_r != nnfh_pkg::S_IDLE, in_stall)
  `NNFH_ASSERT_NEXT(a_space_then_char, state_r == nnfh_pkg::S_MIX_SPACE,
                    state_r == nnfh_pkg::S_MIX_CHAR)
  `NNFH_ASSERT_SAME(a_emit_free, cmd.emit, !sts.out_busy)

endmodule

// ===== test/normalized_name_fnv1a_hash_tb.sv =====
// ----------------------------------------------------------------------------
// normalized_name_fnv1a_hash_tb
// Self-checking bench for the normalized-name FNV-1a hasher. A short directed
// set hits case folding, separator runs, dropped bytes and empty names. Random
// names follow, most of them well-formed and the rest noise, with random
// stalls on both channels. A scoreboard predicts every name hash.
// ----------------------------------------------------------------------------

// Character ranges used by the normalizer
localparam logic [7:0] CH_UPPER_A = 8'h41;
localparam logic [7:0] CH_UPPER_Z = 8'h5A;
localparam logic [7:0] CH_LOWER_A = 8'h61;
localparam logic [7:0] CH_LOWER_Z = 8'h7A;

// Predicts the hash of each name and checks results in order
class name_hash_scoreboard;
  logic [31:0] run_hash;
  bit          letter_seen;
  bit          space_due;
  logic [31:0] hash_q[$];
  int unsigned errors;

  function new();
    clear_name();
    errors = 0;
  endfunction

  function void clear_name();
    run_hash    = nnfh_pkg::FNV_BASIS;
    letter_seen = 1'b0;
    space_due   = 1'b0;
  endfunction

  function logic [31:0] mix(logic [31:0] h, logic [7:0] b);
    return (h ^ {24'd0, b}) * nnfh_pkg::MIX_PRIME;
  endfunction

  // Fold one accepted request into the running name state
  function void note_request(logic [7:0] ch, bit has, bit last);
    logic [7:0] c;
    c = ch;
    if (has) begin
      if (c == nnfh_pkg::CH_SPACE || c == nnfh_pkg::CH_UNDER) begin
        // separators only count once a letter has been seen
        space_due = letter_seen;
      end else begin
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + nnfh_pkg::CASE_BIT;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
          if (space_due) begin
            run_hash  = mix(run_hash, nnfh_pkg::CH_SPACE);
            space_due = 1'b0;
          end
          run_hash    = mix(run_hash, c);
          letter_seen = 1'b1;
        end
      end
    end
    if (last) begin
      hash_q = {hash_q, ((letter_seen && run_hash != 32'd0) ? run_hash : 32'd0)};
      clear_name();
    end
  endfunction

  function void check_hash(logic [31:0] actual);
    logic [31:0] want;
    if (hash_q.size() == 0) begin
      $error("name_hash: unexpected result, actual %h", actual);
      errors++;
    end else begin
      want = hash_q.pop_front();
      if (actual !== want) begin
        $error("name_hash mismatch: expected %h actual %h", want, actual);
        errors++;
      end
    end
  endfunction
endclass

module normalized_name_fnv1a_hash_tb;

  localparam int NAME_REQUESTS = 1250;
  localparam int IDLE_PCT      = 17;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte   = 8'h00;
  logic        in_has_char    = 1'b0;
  logic        in_end_of_name = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [31:0] out_name_hash;

  name_hash_scoreboard sb = new();
  bit quiet = 1'b0;  // no idling on either side while set
  int sent  = 0;     // requests that carry a character or close a name

  normalized_name_fnv1a_hash u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_byte  (in_char_byte),
    .in_has_char   (in_has_char),
    .in_end_of_name(in_end_of_name),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_name_hash (out_name_hash)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stall, check each accepted hash
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_hash(out_name_hash);
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Send one request, with a random gap before it
  task automatic send_request(input logic [7:0] ch, input bit has, input bit last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_byte   <= ch;
    in_has_char    <= has;
    in_end_of_name <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(ch, has, last);
    if (has || last) sent++;
  endtask

  // Pick one character of a well-formed name
  function automatic logic [7:0] name_char();
    int unsigned pick;
    logic [7:0]  letter;
    pick   = $urandom_range(99);
    letter = CH_LOWER_A + 8'($urandom_range(25));
    if (pick < 25) return letter;
    if (pick < 50) return letter - nnfh_pkg::CASE_BIT;
    if (pick < 60) return nnfh_pkg::CH_SPACE;
    if (pick < 70) return nnfh_pkg::CH_UNDER;
    return 8'($urandom_range(255));
  endfunction

  // Random name: content, optional idle requests, closing request
  task automatic random_name();
    int unsigned len;
    len = $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(name_char(), 1'b1, 1'b0);
    end
    if ($urandom_range(1)) send_request(name_char(), 1'b1, 1'b1);
    else send_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Burst of arbitrary requests
  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++)
      send_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                   $urandom_range(5) == 0);
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty name right after reset
    send_request(8'h00, 1'b0, 1'b1);
    // Single letters, character on the closing request
    send_request("A", 1'b1, 1'b1);
    send_request("z", 1'b1, 1'b1);
    // Leading separators set nothing, then close without a character
    send_request(nnfh_pkg::CH_SPACE, 1'b1, 1'b0);
    send_request(nnfh_pkg::CH_UNDER, 1'b1, 1'b0);
    send_request("a", 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    // Separator run with a dropped byte inside collapses to one space
    send_request("a", 1'b1, 1'b0);
    send_request(nnfh_pkg::CH_UNDER, 1'b1, 1'b0);
    send_request("1", 1'b1, 1'b0);
    send_request(nnfh_pkg::CH_SPACE, 1'b1, 1'b0);
    send_request("B", 1'b1, 1'b1);
    // Trailing separator never hashed; idle request in the middle
    send_request("q", 1'b1, 1'b0);
    send_request(8'h41, 1'b0, 1'b0);
    send_request(nnfh_pkg::CH_SPACE, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    // Bytes just outside the letter ranges are dropped
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h40, 1'b1, 1'b0);
    send_request(8'h5B, 1'b1, 1'b0);
    send_request(8'h60, 1'b1, 1'b0);
    send_request(8'h7B, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request("Z", 1'b1, 1'b0);
    send_request("a", 1'b1, 1'b1);
    // Only dropped bytes gives zero
    send_request(8'hC1, 1'b1, 1'b1);

    // Random names, mostly well-formed, with a quiet stretch in the middle
    sent = 0;
    while (sent < NAME_REQUESTS) begin
      quiet = (sent >= 500 && sent < 800);
      if ($urandom_range(99) < 15) noise_burst();
      else random_name();
    end
    // Close any name the noise left open
    send_request(8'h00, 1'b0, 1'b1);
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Drain
    guard = 0;
    while (sb.hash_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (sb.hash_q.size() != 0) begin
      $error("name_hash: %0d expected results never arrived", sb.hash_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/nnfh_pkg.sv
design/nnfh_dpath.sv
design/nnfh_ctrl.sv
design/normalized_name_fnv1a_hash.sv
test/normalized_name_fnv1a_hash_tb.sv
